// ===== rtl/cld_pkg.sv =====
// Shared types, widths and constants of the CPU load meter.
package cld_pkg;

  localparam int unsigned CLD_MAX_STEPS = 1024;
  localparam int unsigned CLD_FRAC_BITS = 16;

  localparam int unsigned TIME_W     = 56;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned TICKS_W    = 24;
  localparam int unsigned SFRAC_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // gains are Q8.8, step fraction is Q0.16
  localparam int unsigned GAIN_FRAC = 8;
  localparam int unsigned SF_FRAC   = 16;

  localparam logic [GAIN_W-1:0]  SPRING_RST  = 16'd2560;
  localparam logic [GAIN_W-1:0]  DAMPING_RST = 16'd1280;
  localparam logic [TICKS_W-1:0] TICKS_RST   = 24'd1000000;
  localparam logic [SFRAC_W-1:0] SFRAC_RST   = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRING     = 2'd0,
    CFG_DAMPING    = 2'd1,
    CFG_STEP_TICKS = 2'd2,
    CFG_STEP_FRAC  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_DIV,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } cld_state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic prep;
    logic div_step;
    logic mul0;
    logic mul1;
    logic mul2;
    logic mul3;
    logic publish;
  } cld_cmd_t;

  typedef struct packed {
    logic exited;
    logic advance;
    logic div_skip;
    logic div_last;
    logic step_last;
  } cld_status_t;

endpackage

// ===== rtl/cld_ifs.sv =====
// Valid/ready channel interfaces for poll words and result words.
interface cld_in_if;
  import cld_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_time;
  logic [TIME_W-1:0] user_time;
  logic [TIME_W-1:0] kernel_time;
  logic              process_exited;

  modport source (output valid, now_time, user_time, kernel_time, process_exited,
                  input ready);
  modport sink (input valid, now_time, user_time, kernel_time, process_exited,
                output ready);
endinterface

interface cld_out_if;
  import cld_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    running;
  logic signed [POS_W-1:0] position;

  modport source (output valid, running, position, input ready);
  modport sink (input valid, running, position, output ready);
endinterface

// ===== rtl/cld_ctrl.sv =====
// Sequencer: poll intake, load division, integration step phases, result hand-off.
module cld_ctrl import cld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cld_status_t status_i,
  output cld_cmd_t    cmd_o
);

  cld_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.exited || !status_i.advance) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.div_skip ? ST_MUL0 : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = status_i.step_last ? ST_DONE : ST_MUL0;
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/cld_dpath.sv =====
// Datapath: config registers, poll state, load divider, spring-damper integrator.
module cld_dpath import cld_pkg::*; #(
  parameter int unsigned FRAC_BITS = CLD_FRAC_BITS,
  parameter int unsigned MAX_STEPS = CLD_MAX_STEPS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [TIME_W-1:0]       now_time_i,
  input  logic [TIME_W-1:0]       user_time_i,
  input  logic [TIME_W-1:0]       kernel_time_i,
  input  logic                    process_exited_i,
  input  cld_cmd_t                cmd_i,
  output cld_status_t             status_o,
  output logic                    running_o,
  output logic signed [POS_W-1:0] position_o
);

  localparam int unsigned NUM_W  = TIME_W + 2;          // signed sum of two deltas
  localparam int unsigned REM_W  = TIME_W + 4;          // divider remainder
  localparam int unsigned QUO_W  = FRAC_BITS + 4;       // 4 integer + fraction bits
  localparam int unsigned FRAC_W = FRAC_BITS + 5;       // holds 16.0 exactly
  localparam int unsigned DCNT_W = $clog2(QUO_W);
  localparam int unsigned SCNT_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned GS_W   = GAIN_W + 1;
  localparam int unsigned DIFF_W = ((FRAC_W + 1 > POS_W) ? FRAC_W + 1 : POS_W) + 1;
  localparam int unsigned KP_W   = DIFF_W + GS_W;
  localparam int unsigned DP_W   = POS_W + GS_W;
  localparam int unsigned RAW_W  = ((KP_W > DP_W) ? KP_W : DP_W) + 1;
  localparam int unsigned ACC_W  = RAW_W - GAIN_FRAC;
  localparam int unsigned AP_W   = ACC_W + SFRAC_W + 1;
  localparam int unsigned DV_W   = AP_W - SF_FRAC;
  localparam int unsigned VS_W   = ((DV_W > POS_W) ? DV_W : POS_W) + 1;
  localparam int unsigned PP_W   = POS_W + SFRAC_W + 1;
  localparam int unsigned PD_W   = PP_W - SF_FRAC;
  localparam int unsigned PS_W   = ((PD_W > POS_W) ? PD_W : POS_W) + 1;
  localparam int unsigned SAT_W  = (VS_W > PS_W) ? VS_W : PS_W;

  localparam logic [QUO_W-1:0]  QUO_LAST  = QUO_W'(QUO_W - 1);
  localparam logic [SCNT_W-1:0] STEP_LAST = SCNT_W'(MAX_STEPS - 1);
  localparam logic [FRAC_W-1:0] FRAC_MAX  = FRAC_W'(1) << (FRAC_BITS + 4);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    logic signed [POS_W-1:0] res;
    if (v[SAT_W-1:POS_W-1] == '0 || v[SAT_W-1:POS_W-1] == '1) begin
      res = v[POS_W-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

  // configuration
  logic [GAIN_W-1:0]  spring_q, damping_q;
  logic [TICKS_W-1:0] ticks_q;
  logic [SFRAC_W-1:0] sfrac_q;

  // poll state
  logic [TIME_W-1:0]       prev_user_q, prev_kernel_q, last_time_q;
  logic signed [POS_W-1:0] pos_q, vel_q;
  logic [SCNT_W-1:0]       step_cnt_q;
  logic [DCNT_W-1:0]       div_cnt_q;

  // captured word and working registers
  logic [TIME_W-1:0]       now_q, user_q, kern_q;
  logic                    exited_q;
  logic [TIME_W-1:0]       elapsed_q, rem_ticks_q;
  logic signed [NUM_W-1:0] num_q;
  logic [REM_W-1:0]        div_rem_q;
  logic [QUO_W-1:0]        quo_q;
  logic [FRAC_W-1:0]       frac_q;
  logic signed [KP_W-1:0]  prod_k_q;
  logic signed [DP_W-1:0]  prod_d_q;
  logic signed [AP_W-1:0]  acc_prod_q;
  logic signed [PP_W-1:0]  pos_prod_q;
  logic                    running_q;
  logic signed [POS_W-1:0] res_pos_q;

  // combinational
  logic [TICKS_W-1:0]      st_eff;
  logic signed [NUM_W-1:0] num_d;
  logic                    num_pos, clamp;
  logic [REM_W-1:0]        div_den, div_diff;
  logic                    div_ge;
  logic [QUO_W-1:0]        quo_d;
  logic signed [GS_W-1:0]  sg_s, dg_s, sf_s;
  logic signed [DIFF_W-1:0] diff;
  logic signed [RAW_W-1:0] raw;
  logic signed [ACC_W-1:0] accel;
  logic signed [DV_W-1:0]  dvel;
  logic signed [VS_W-1:0]  vel_sum;
  logic signed [POS_W-1:0] vel_new;
  logic signed [PD_W-1:0]  dpos;
  logic signed [PS_W-1:0]  pos_sum;
  logic                    rem_done;

  assign st_eff  = (ticks_q == '0) ? TICKS_W'(1) : ticks_q;
  assign num_d   = (NUM_W'(user_q) - NUM_W'(prev_user_q))
                 + (NUM_W'(kern_q) - NUM_W'(prev_kernel_q));
  assign num_pos = !num_q[NUM_W-1] && (num_q != '0);
  assign clamp   = REM_W'(num_q[NUM_W-2:0]) >= {elapsed_q, 4'b0};

  // one quotient bit per cycle against elapsed*8; remainder shifts left
  assign div_den  = REM_W'({elapsed_q, 3'b0});
  assign div_ge   = div_rem_q >= div_den;
  assign div_diff = div_ge ? (div_rem_q - div_den) : div_rem_q;
  assign quo_d    = {quo_q[QUO_W-2:0], div_ge};

  assign sg_s = $signed({1'b0, spring_q});
  assign dg_s = $signed({1'b0, damping_q});
  assign sf_s = $signed({1'b0, sfrac_q});
  assign diff = DIFF_W'($signed({1'b0, frac_q})) - DIFF_W'(pos_q);

  assign raw     = RAW_W'(prod_k_q) - RAW_W'(prod_d_q);
  assign accel   = $signed(raw[RAW_W-1:GAIN_FRAC]);
  assign dvel    = $signed(acc_prod_q[AP_W-1:SF_FRAC]);
  assign vel_sum = VS_W'(vel_q) + VS_W'(dvel);
  assign vel_new = sat_pos(SAT_W'(vel_sum));
  assign dpos    = $signed(pos_prod_q[PP_W-1:SF_FRAC]);
  assign pos_sum = PS_W'(pos_q) + PS_W'(dpos);
  assign rem_done = rem_ticks_q <= TIME_W'(st_eff);

  assign status_o.exited    = exited_q;
  assign status_o.advance   = (last_time_q != '0) && (now_q > last_time_q);
  assign status_o.div_skip  = !num_pos || clamp;
  assign status_o.div_last  = QUO_W'(div_cnt_q) == QUO_LAST;
  assign status_o.step_last = rem_done || (step_cnt_q == STEP_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q      <= SPRING_RST;
      damping_q     <= DAMPING_RST;
      ticks_q       <= TICKS_RST;
      sfrac_q       <= SFRAC_RST;
      prev_user_q   <= '0;
      prev_kernel_q <= '0;
      last_time_q   <= '0;
      pos_q         <= '0;
      vel_q         <= '0;
      step_cnt_q    <= '0;
      div_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_SPRING:     spring_q  <= cfg_data_i[GAIN_W-1:0];
          CFG_DAMPING:    damping_q <= cfg_data_i[GAIN_W-1:0];
          CFG_STEP_TICKS: ticks_q   <= cfg_data_i[TICKS_W-1:0];
          CFG_STEP_FRAC:  sfrac_q   <= cfg_data_i[SFRAC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.check) begin
        step_cnt_q <= '0;
      end
      if (cmd_i.prep) begin
        div_cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.mul2) begin
        vel_q <= vel_new;
      end
      if (cmd_i.mul3) begin
        pos_q      <= sat_pos(SAT_W'(pos_sum));
        step_cnt_q <= step_cnt_q + 1'b1;
      end
      if (cmd_i.publish && !exited_q) begin
        prev_user_q   <= user_q;
        prev_kernel_q <= kern_q;
        last_time_q   <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q    <= now_time_i;
      user_q   <= user_time_i;
      kern_q   <= kernel_time_i;
      exited_q <= process_exited_i;
    end
    if (cmd_i.check) begin
      elapsed_q   <= now_q - last_time_q;
      rem_ticks_q <= now_q - last_time_q;
      num_q       <= num_d;
    end
    if (cmd_i.prep) begin
      frac_q    <= (num_pos && clamp) ? FRAC_MAX : '0;
      div_rem_q <= REM_W'(num_q[NUM_W-2:0]);
      quo_q     <= '0;
    end
    if (cmd_i.div_step) begin
      div_rem_q <= {div_diff[REM_W-2:0], 1'b0};
      quo_q     <= quo_d;
      if (status_o.div_last) begin
        frac_q <= FRAC_W'(quo_d);
      end
    end
    if (cmd_i.mul0) begin
      prod_k_q <= KP_W'(sg_s) * KP_W'(diff);
      prod_d_q <= DP_W'(dg_s) * DP_W'(vel_q);
    end
    if (cmd_i.mul1) begin
      acc_prod_q <= AP_W'(accel) * AP_W'(sf_s);
    end
    if (cmd_i.mul2) begin
      pos_prod_q <= PP_W'(vel_new) * PP_W'(sf_s);
    end
    if (cmd_i.mul3) begin
      rem_ticks_q <= rem_done ? '0 : (rem_ticks_q - TIME_W'(st_eff));
    end
    if (cmd_i.publish) begin
      running_q <= !exited_q;
      res_pos_q <= pos_q;
    end
  end

  assign running_o  = running_q;
  assign position_o = res_pos_q;

endmodule

// ===== rtl/cpu_load_spring_damper_meter.sv =====
// CPU load meter with a spring-damper needle: top level.
// Each poll word gives the wall time, the process's cumulative user and kernel CPU
// times and an exited flag; one result word (running, position) comes back per poll.
// One poll is worked at a time. A poll that marks the process exited, the first poll
// and a poll whose time does not advance skip from the check phase to the result.
// Otherwise a restoring divider gives the load fraction in FRAC_BITS+4 quotient bits
// (skipped when the load is zero or negative or clamps at 16), and the needle then
// runs each integration step through MUL0..MUL3 (two multiply stages for acceleration,
// one each for velocity and position), for ceil(elapsed/step_ticks) steps capped at
// MAX_STEPS.
// The result register lets the next poll be accepted while a result waits.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not enforce it.
module cpu_load_spring_damper_meter import cld_pkg::*; #(
  parameter int unsigned FRAC_BITS = CLD_FRAC_BITS,
  parameter int unsigned MAX_STEPS = CLD_MAX_STEPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cld_in_if.sink                in_i,
  cld_out_if.source             out_o
);

  cld_cmd_t    cmd;
  cld_status_t status;
  logic        in_rdy;
  logic        out_vld;

  cld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_rdy),
    .out_valid_o (out_vld),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cld_dpath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .now_time_i       (in_i.now_time),
    .user_time_i      (in_i.user_time),
    .kernel_time_i    (in_i.kernel_time),
    .process_exited_i (in_i.process_exited),
    .cmd_i            (cmd),
    .status_o         (status),
    .running_o        (out_o.running),
    .position_o       (out_o.position)
  );

  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_vld;

`ifndef SYNTH
  a_accept_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd.check)
    else $error("accepted word not followed by check phase");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_o.valid)
    else $error("published result not presented");

  a_exited_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.publish && status.exited) |=> !out_o.running)
    else $error("exited poll reported as running");
`endif

endmodule
